// File: design/tpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared widths, limits and types of the triangle/plane clipper.
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  localparam int NUM_REGS = 6;
  localparam int CFG_DW   = (COORD_WIDTH > 32) ? 64 : 32;
  localparam int CFG_LSB  = (COORD_WIDTH > 32) ? 3 : 2;
  localparam int CFG_AW   = CFG_LSB + 3;

  localparam int MAX_VTX  = 4;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  localparam coord_t CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   crossing;
  } vtx_t;

endpackage
`default_nettype wire

// File: design/tpc_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpc channel interfaces
// Triangle request channel and clipped vertex channel, valid/ready.
// ----------------------------------------------------------------------------
interface tpc_tri_if import tpc_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t first_x;
  coord_t first_y;
  coord_t first_z;
  coord_t second_x;
  coord_t second_y;
  coord_t second_z;
  coord_t third_x;
  coord_t third_y;
  coord_t third_z;

  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  third_x, third_y, third_z, input ready);
  modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                third_x, third_y, third_z, output ready);
endinterface

interface tpc_vtx_if import tpc_pkg::*; ();
  logic       valid;
  logic       ready;
  coord_t     out_x;
  coord_t     out_y;
  coord_t     out_z;
  logic       is_crossing;
  logic [2:0] vertex_total;
  logic       last;

  modport source (output valid, out_x, out_y, out_z, is_crossing, vertex_total, last,
                  input ready);
  modport sink (input valid, out_x, out_y, out_z, is_crossing, vertex_total, last,
                output ready);
endinterface
`default_nettype wire

// File: design/triangle_plane_clipper.sv
// The pipeline holds COORD_WIDTH + 8 = 40 register stages from input to head.
// Throughput: one triangle may enter each cycle while the head is free; the output
// drains one vertex per cycle while ready is high, and the input stalls while the head still has vertices left to emit.
// The long pole is the bit-serial crossing divider, one quotient bit per stage.
// Reset (rst_n, synchronous, active low) empties the pipeline and zeroes the plane.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_plane_clipper
// Sutherland-Hodgman clip of one triangle against one plane, fully pipelined.
// ----------------------------------------------------------------------------
module triangle_plane_clipper import tpc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  tpc_tri_if.sink                in_tri,
  tpc_vtx_if.source              out_vtx,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  localparam int CW = COORD_WIDTH;
  localparam int PW = 2*CW + 1;
  localparam int SW = CW + 2;
  localparam logic signed [PW-1:0] RND = PW'((64'd1 << FRAC_BITS) - 64'd1);

  function automatic coord_t sat_wide(input logic signed [PW-1:0] a);
    logic fits;
    fits = (&a[PW-1:CW-1]) | ~(|a[PW-1:CW-1]);
    return fits ? a[CW-1:0] : (a[PW-1] ? CMIN : CMAX);
  endfunction

  // ---------------- plane registers ----------------
  coord_t     cfg_r [0:NUM_REGS-1];
  logic [2:0] cfg_idx;
  logic       cfg_wr;

  assign cfg_idx    = cfg_paddr[CFG_AW-1:CFG_LSB];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (32'(cfg_idx) < NUM_REGS) ? CFG_DW'(cfg_r[cfg_idx]) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_REGS; r++) cfg_r[r] <= '0;
    end else if (cfg_wr && (32'(cfg_idx) < NUM_REGS)) begin
      cfg_r[cfg_idx] <= cfg_pwdata[CW-1:0];
    end
  end

  // ---------------- pipeline registers ----------------
  logic adv;

  coord_t v_in [3][3];

  logic                 s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  coord_t               s1_vtx_r [3][3];
  coord_t               s2_vtx_r [3][3];
  coord_t               s3_vtx_r [3][3];
  coord_t               s4_vtx_r [3][3];
  coord_t               s5_vtx_r [3][3];
  logic signed [CW:0]   s1_u_r [3][3];
  logic signed [CW:0]   s1_u_nxt [3][3];
  logic signed [PW-1:0] s2_prod_r [3][3];
  logic signed [PW-1:0] s2_prod_nxt [3][3];
  coord_t               s3_term_r [3][3];
  coord_t               s3_term_nxt [3][3];
  coord_t               s4_d_r [3];
  coord_t               s4_d_nxt [3];
  logic [2:0]           s5_keep_r, s5_keep_nxt;
  logic [2:0]           s5_cross_r, s5_cross_nxt;
  logic [CW-1:0]        s5_dmag_r [3];
  logic [CW-1:0]        s5_dmag_nxt [3];
  logic [CW:0]          s5_den_r [3];
  logic [CW:0]          s5_den_nxt [3];
  logic [CW-1:0]        s5_delm_r [3][3];
  logic [CW-1:0]        s5_delm_nxt [3][3];
  logic [2:0]           s5_neg_r [3];
  logic [2:0]           s5_neg_nxt [3];

  // divider stages: index 0 holds the products, index CW the finished quotients
  logic                 dv_r [0:CW];
  logic [2*CW-1:0]      div_rem_r [0:CW][3][3];
  logic [2*CW-1:0]      div_rem_nxt [0:CW][3][3];
  logic [CW-1:0]        div_q_r [0:CW][3][3];
  logic [CW-1:0]        div_q_nxt [0:CW][3][3];
  logic [CW:0]          div_den_r [0:CW][3];
  coord_t               div_vtx_r [0:CW][3][3];
  logic [2:0]           div_keep_r [0:CW];
  logic [2:0]           div_cross_r [0:CW];
  logic [2:0]           div_neg_r [0:CW][3];

  logic                 f_v_r;
  coord_t               f_vtx_r [3][3];
  coord_t               f_crs_r [3][3];
  coord_t               f_crs_nxt [3][3];
  logic [2:0]           f_keep_r, f_cross_r;

  vtx_t                 hd_list_r [MAX_VTX];
  vtx_t                 hd_list_nxt [MAX_VTX];
  logic [2:0]           hd_cnt_r, hd_cnt_nxt;
  logic [1:0]           hd_idx_r;
  logic                 hd_v_r;
  logic                 hd_last, hd_done;

  always_comb begin
    v_in[0][0] = in_tri.first_x;
    v_in[0][1] = in_tri.first_y;
    v_in[0][2] = in_tri.first_z;
    v_in[1][0] = in_tri.second_x;
    v_in[1][1] = in_tri.second_y;
    v_in[1][2] = in_tri.second_z;
    v_in[2][0] = in_tri.third_x;
    v_in[2][1] = in_tri.third_y;
    v_in[2][2] = in_tri.third_z;
  end

  // ---------------- datapath ----------------
  always_comb begin : dp_comb
    logic signed [PW-1:0] adj;
    logic signed [PW-1:0] sh;
    logic signed [SW-1:0] sum;
    logic signed [CW:0]   den, d0w, dl, qs;
    logic [2*CW-1:0]      sd;
    logic                 ge;
    int                   j;

    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        s1_u_nxt[i][k]    = (CW+1)'(v_in[i][k]) - (CW+1)'(cfg_r[3+k]);
        s2_prod_nxt[i][k] = PW'(s1_u_r[i][k]) * PW'(cfg_r[k]);
        // truncate toward zero: bias negatives before the shift
        adj = s2_prod_r[i][k] + (s2_prod_r[i][k][PW-1] ? RND : '0);
        sh  = adj >>> FRAC_BITS;
        s3_term_nxt[i][k] = sat_wide(sh);
      end
      sum = SW'(s3_term_r[i][0]) + SW'(s3_term_r[i][1]) + SW'(s3_term_r[i][2]);
      s4_d_nxt[i] = sat_wide(PW'(sum));
    end

    for (int e = 0; e < 3; e++) begin
      j = (e == 2) ? 0 : e + 1;
      s5_keep_nxt[e]  = ~s4_d_r[e][CW-1];
      s5_cross_nxt[e] = (s4_d_r[e] < 0 && s4_d_r[j] > 0) || (s4_d_r[e] > 0 && s4_d_r[j] < 0);
      den = (CW+1)'(s4_d_r[e]) - (CW+1)'(s4_d_r[j]);
      s5_den_nxt[e] = den[CW] ? -den : den;
      d0w = (CW+1)'(s4_d_r[e]);
      d0w = d0w[CW] ? -d0w : d0w;
      s5_dmag_nxt[e] = d0w[CW-1:0];
      for (int k = 0; k < 3; k++) begin
        dl = (CW+1)'(s4_vtx_r[j][k]) - (CW+1)'(s4_vtx_r[e][k]);
        // on a crossing d0 and d0-d1 share a sign, so only delta sets the sign
        s5_neg_nxt[e][k] = dl[CW];
        dl = dl[CW] ? -dl : dl;
        s5_delm_nxt[e][k] = dl[CW-1:0];
        div_rem_nxt[0][e][k] = (2*CW)'(s5_dmag_r[e]) * (2*CW)'(s5_delm_r[e][k]);
        div_q_nxt[0][e][k]   = '0;
      end
    end

    // restoring division, one quotient bit per stage, MSB first
    for (int t = 0; t < CW; t++) begin
      for (int e = 0; e < 3; e++) begin
        sd = (2*CW)'(div_den_r[t][e]) << (CW - 1 - t);
        for (int k = 0; k < 3; k++) begin
          ge = div_rem_r[t][e][k] >= sd;
          div_rem_nxt[t+1][e][k] = ge ? div_rem_r[t][e][k] - sd : div_rem_r[t][e][k];
          div_q_nxt[t+1][e][k]   = {div_q_r[t][e][k][CW-2:0], ge};
        end
      end
    end

    for (int e = 0; e < 3; e++) begin
      for (int k = 0; k < 3; k++) begin
        qs = $signed({1'b0, div_q_r[CW][e][k]});
        qs = div_neg_r[CW][e][k] ? -qs : qs;
        sum = SW'(div_vtx_r[CW][e][k]) + SW'(qs);
        f_crs_nxt[e][k] = sat_wide(PW'(sum));
      end
    end
  end

  // ---------------- compaction into the output list ----------------
  always_comb begin : cmp_comb
    logic [2:0] pos;
    vtx_t       cand;
    pos = '0;
    for (int s = 0; s < MAX_VTX; s++) hd_list_nxt[s] = '0;
    for (int e = 0; e < 3; e++) begin
      cand = '{x: f_vtx_r[e][0], y: f_vtx_r[e][1], z: f_vtx_r[e][2], crossing: 1'b0};
      if (f_keep_r[e]) begin
        if (pos < 3'(MAX_VTX)) hd_list_nxt[pos[1:0]] = cand;
        pos = pos + 3'd1;
      end
      cand = '{x: f_crs_r[e][0], y: f_crs_r[e][1], z: f_crs_r[e][2], crossing: 1'b1};
      if (f_cross_r[e]) begin
        if (pos < 3'(MAX_VTX)) hd_list_nxt[pos[1:0]] = cand;
        pos = pos + 3'd1;
      end
    end
    hd_cnt_nxt = (pos > 3'(MAX_VTX)) ? 3'(MAX_VTX) : pos;
  end

  // ---------------- head / output ----------------
  assign hd_last = ({1'b0, hd_idx_r} == hd_cnt_r - 3'd1);
  assign hd_done = hd_v_r & out_vtx.ready & hd_last;
  assign adv     = ~hd_v_r | hd_done;

  assign in_tri.ready         = adv;
  assign out_vtx.valid        = hd_v_r;
  assign out_vtx.out_x        = hd_list_r[hd_idx_r].x;
  assign out_vtx.out_y        = hd_list_r[hd_idx_r].y;
  assign out_vtx.out_z        = hd_list_r[hd_idx_r].z;
  assign out_vtx.is_crossing  = hd_list_r[hd_idx_r].crossing;
  assign out_vtx.vertex_total = hd_cnt_r;
  assign out_vtx.last         = hd_last;

  // valid bits and head control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      s3_v_r   <= 1'b0;
      s4_v_r   <= 1'b0;
      s5_v_r   <= 1'b0;
      for (int t = 0; t <= CW; t++) dv_r[t] <= 1'b0;
      f_v_r    <= 1'b0;
      hd_v_r   <= 1'b0;
      hd_idx_r <= '0;
      hd_cnt_r <= '0;
    end else if (adv) begin
      s1_v_r  <= in_tri.valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      dv_r[0] <= s5_v_r;
      for (int t = 0; t < CW; t++) dv_r[t+1] <= dv_r[t];
      f_v_r    <= dv_r[CW];
      // drop triangles that lie fully behind the plane
      hd_v_r   <= f_v_r && (hd_cnt_nxt != 3'd0);
      hd_idx_r <= '0;
      hd_cnt_r <= hd_cnt_nxt;
    end else if (out_vtx.ready) begin
      hd_idx_r <= hd_idx_r + 2'd1;
    end
  end

  // payload, advances with the pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_vtx_r   <= v_in;
      s1_u_r     <= s1_u_nxt;
      s2_vtx_r   <= s1_vtx_r;
      s2_prod_r  <= s2_prod_nxt;
      s3_vtx_r   <= s2_vtx_r;
      s3_term_r  <= s3_term_nxt;
      s4_vtx_r   <= s3_vtx_r;
      s4_d_r     <= s4_d_nxt;
      s5_vtx_r   <= s4_vtx_r;
      s5_keep_r  <= s5_keep_nxt;
      s5_cross_r <= s5_cross_nxt;
      s5_dmag_r  <= s5_dmag_nxt;
      s5_den_r   <= s5_den_nxt;
      s5_delm_r  <= s5_delm_nxt;
      s5_neg_r   <= s5_neg_nxt;

      div_rem_r[0]   <= div_rem_nxt[0];
      div_q_r[0]     <= div_q_nxt[0];
      div_den_r[0]   <= s5_den_r;
      div_vtx_r[0]   <= s5_vtx_r;
      div_keep_r[0]  <= s5_keep_r;
      div_cross_r[0] <= s5_cross_r;
      div_neg_r[0]   <= s5_neg_r;
      for (int t = 0; t < CW; t++) begin
        div_rem_r[t+1]   <= div_rem_nxt[t+1];
        div_q_r[t+1]     <= div_q_nxt[t+1];
        div_den_r[t+1]   <= div_den_r[t];
        div_vtx_r[t+1]   <= div_vtx_r[t];
        div_keep_r[t+1]  <= div_keep_r[t];
        div_cross_r[t+1] <= div_cross_r[t];
        div_neg_r[t+1]   <= div_neg_r[t];
      end

      f_vtx_r   <= div_vtx_r[CW];
      f_crs_r   <= f_crs_nxt;
      f_keep_r  <= div_keep_r[CW];
      f_cross_r <= div_cross_r[CW];

      hd_list_r <= hd_list_nxt;
    end
  end

endmodule
`default_nettype wire
